### rtl/ffra_pkg.sv
// Shared types and constants for the first-fit range allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package ffra_pkg;

  // Table and address space sizes
  localparam int FREE_SLOTS = 64;
  localparam int SPACE_BITS = 24;
  localparam int LEN_W      = SPACE_BITS + 1;
  localparam int IDX_W      = $clog2(FREE_SLOTS);
  // Counters reach one past the entry count, so they hold FREE_SLOTS + 1
  localparam int CNT_W      = $clog2(FREE_SLOTS + 2);

  localparam logic [LEN_W-1:0] SPACE_SIZE = {1'b1, {SPACE_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] SLOTS_CNT  = CNT_W'(FREE_SLOTS);

  // Request types
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE   = 2'd1;
  localparam logic [1:0] STAT_TABLE_FULL = 2'd2;

  // One free-table entry
  typedef struct packed {
    logic [SPACE_BITS-1:0] start;
    logic [LEN_W-1:0]      len;
  } entry_t;

  // Source of a free-table write
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CARVE,
    WR_MERGE_BOTH,
    WR_MERGE_PREV,
    WR_MERGE_NEXT,
    WR_NEW,
    WR_MOVE_DN,
    WR_MOVE_UP
  } wr_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CARVE,
    ST_HWM,
    ST_DECIDE,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_INSERT,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       req_load;
    logic       rd_en;
    logic       rd_down;
    logic       pos_load;
    logic       prev_load;
    logic       sd_start;
    logic       su_start;
    wr_sel_t    wr_sel;
    logic       used_inc;
    logic       used_dec;
    logic       grant_entry;
    logic       grant_hw;
    logic       hw_advance;
    logic       status_set;
    logic [1:0] status_val;
    logic       out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_rel_zero;
    logic req_is_rel;
    logic cur_valid;
    logic cur_past;
    logic fit;
    logic at_or_after;
    logic carve_empty;
    logic hw_ok;
    logic join_prev;
    logic join_next;
    logic table_full;
    logic pos_at_end;
    logic cur_at_pos;
    logic out_free;
  } flags_t;

endpackage

### rtl/ffra_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ffra_ctrl.sv
// Request sequencer: scan, carve, merge and shift steps of the allocator.
// Depends on ffra_pkg; drives the datapath through cmd_t, reads flags_t.
module ffra_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffra_pkg::flags_t flags,
  output ffra_pkg::cmd_t   cmd
);

  import ffra_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = flags.in_rel_zero ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (flags.cur_valid) begin
          if (!flags.req_is_rel) begin
            if (flags.cur_past) begin
              state_next = ST_HWM;
            end else if (flags.fit) begin
              state_next = ST_CARVE;
            end
          end else if (flags.cur_past || flags.at_or_after) begin
            state_next = ST_DECIDE;
          end
        end
      end
      ST_CARVE:  state_next = flags.carve_empty ? ST_SHIFT_DN : ST_FINISH;
      ST_HWM:    state_next = ST_FINISH;
      ST_DECIDE: begin
        if (flags.join_prev && flags.join_next) begin
          state_next = ST_SHIFT_DN;
        end else if (flags.join_prev || flags.join_next || flags.table_full) begin
          state_next = ST_FINISH;
        end else if (flags.pos_at_end) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_SHIFT_UP;
        end
      end
      ST_SHIFT_DN: begin
        if (flags.cur_valid && flags.cur_past) begin
          state_next = ST_FINISH;
        end
      end
      ST_SHIFT_UP: begin
        if (flags.cur_valid && flags.cur_at_pos) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (flags.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd        = '0;
    cmd.wr_sel = WR_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.req_load = in_valid;
      end
      ST_SCAN: begin
        if (!flags.cur_valid) begin
          cmd.rd_en = 1'b1;
        end else if (!flags.req_is_rel) begin
          if (!flags.cur_past && flags.fit) begin
            cmd.pos_load = 1'b1;
          end else if (!flags.cur_past) begin
            cmd.rd_en = 1'b1;
          end
        end else if (flags.cur_past || flags.at_or_after) begin
          cmd.pos_load = 1'b1;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.prev_load = 1'b1;
        end
      end
      ST_CARVE: begin
        cmd.grant_entry = 1'b1;
        if (flags.carve_empty) begin
          cmd.sd_start = 1'b1;
        end else begin
          cmd.wr_sel = WR_CARVE;
        end
      end
      ST_HWM: begin
        if (flags.hw_ok) begin
          cmd.grant_hw   = 1'b1;
          cmd.hw_advance = 1'b1;
        end else begin
          cmd.status_set = 1'b1;
          cmd.status_val = STAT_NO_SPACE;
        end
      end
      ST_DECIDE: begin
        if (flags.join_prev && flags.join_next) begin
          cmd.wr_sel   = WR_MERGE_BOTH;
          cmd.sd_start = 1'b1;
        end else if (flags.join_prev) begin
          cmd.wr_sel = WR_MERGE_PREV;
        end else if (flags.join_next) begin
          cmd.wr_sel = WR_MERGE_NEXT;
        end else if (flags.table_full) begin
          cmd.status_set = 1'b1;
          cmd.status_val = STAT_TABLE_FULL;
        end else if (!flags.pos_at_end) begin
          cmd.su_start = 1'b1;
        end
      end
      ST_SHIFT_DN: begin
        if (flags.cur_valid && flags.cur_past) begin
          cmd.used_dec = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
          if (flags.cur_valid) begin
            cmd.wr_sel = WR_MOVE_DN;
          end
        end
      end
      ST_SHIFT_UP: begin
        cmd.rd_down = 1'b1;
        if (flags.cur_valid) begin
          cmd.wr_sel = WR_MOVE_UP;
        end
        cmd.rd_en = !(flags.cur_valid && flags.cur_at_pos);
      end
      ST_INSERT: begin
        cmd.wr_sel   = WR_NEW;
        cmd.used_inc = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = flags.out_free;
      end
      default: begin
        cmd.wr_sel = WR_NONE;
      end
    endcase
  end

endmodule

### rtl/ffra_datapath.sv
// Allocator datapath: free-range RAM, scan pointers, request, mark and result registers.
// Depends on ffra_pkg and ffra_ram; obeys cmd_t from the controller.
module ffra_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ffra_pkg::LEN_W-1:0]          cfg_wdata,
  input  logic                                req_type,
  input  logic [ffra_pkg::SPACE_BITS-1:0]     range_first,
  input  logic [ffra_pkg::LEN_W-1:0]          range_length,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ffra_pkg::SPACE_BITS-1:0]     granted_first,
  output logic [1:0]                          status,
  input  ffra_pkg::cmd_t                      cmd,
  output ffra_pkg::flags_t                    flags
);

  import ffra_pkg::*;

  logic [LEN_W-1:0]      space_limit;
  logic [CNT_W-1:0]      used;
  logic [LEN_W-1:0]      high_water;
  logic                  req_rel;
  logic [SPACE_BITS-1:0] req_first;
  logic [LEN_W-1:0]      req_len;
  logic [LEN_W-1:0]      req_end;
  logic [CNT_W-1:0]      rd_idx;
  logic [CNT_W-1:0]      cur_idx;
  logic                  cur_valid;
  logic [CNT_W-1:0]      pos;
  logic [SPACE_BITS-1:0] prev_start;
  logic [LEN_W-1:0]      prev_len;
  logic [LEN_W-1:0]      prev_end;
  logic                  prev_valid;
  logic [SPACE_BITS-1:0] grant_w;
  logic [1:0]            status_w;

  entry_t                cur;
  entry_t                wr_data;
  logic [CNT_W-1:0]      wr_addr;
  logic                  wr_en;

  logic [LEN_W:0]        rel_sum;
  logic                  rel_clip;
  logic [LEN_W:0]        hw_sum;
  logic [LEN_W-1:0]      limit_eff;

  // Free-range table
  ffra_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (FREE_SLOTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr[IDX_W-1:0]),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (cur)
  );

  // Release end, clipped to the top of the space
  assign rel_sum  = {2'b00, range_first} + {1'b0, range_length};
  assign rel_clip = rel_sum > {1'b0, SPACE_SIZE};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      space_limit <= SPACE_SIZE;
    end else if (cfg_we) begin
      space_limit <= cfg_wdata;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_rel   <= req_type;
      req_first <= range_first;
      req_end   <= rel_clip ? SPACE_SIZE : rel_sum[LEN_W-1:0];
      if (req_type == REQ_RELEASE && rel_clip) begin
        req_len <= SPACE_SIZE - {1'b0, range_first};
      end else begin
        req_len <= range_length;
      end
    end
  end

  // Read pointer and the index of the entry in the read register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else begin
      cur_valid <= cmd.rd_en;
    end
    if (cmd.req_load) begin
      rd_idx <= '0;
    end else if (cmd.sd_start) begin
      rd_idx <= pos + 1'b1;
    end else if (cmd.su_start) begin
      rd_idx <= used - 1'b1;
    end else if (cmd.rd_en) begin
      rd_idx <= cmd.rd_down ? rd_idx - 1'b1 : rd_idx + 1'b1;
    end
    if (cmd.rd_en) begin
      cur_idx <= rd_idx;
    end
    if (cmd.pos_load) begin
      pos <= cur_idx;
    end
  end

  // Entry just before the insert point
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
    end else if (cmd.req_load) begin
      prev_valid <= 1'b0;
    end else if (cmd.prev_load) begin
      prev_valid <= 1'b1;
    end
    if (cmd.prev_load) begin
      prev_start <= cur.start;
      prev_len   <= cur.len;
      prev_end   <= {1'b0, cur.start} + cur.len;
    end
  end

  // Entry count and high-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      high_water <= '0;
    end else begin
      if (cmd.used_inc) begin
        used <= used + 1'b1;
      end else if (cmd.used_dec) begin
        used <= used - 1'b1;
      end
      if (cmd.hw_advance) begin
        high_water <= high_water + req_len;
      end
    end
  end

  // Table write source
  always_comb begin
    wr_addr = pos;
    wr_data = cur;
    wr_en   = cmd.wr_sel != WR_NONE;
    case (cmd.wr_sel)
      WR_CARVE: begin
        wr_data.start = cur.start + req_len[SPACE_BITS-1:0];
        wr_data.len   = cur.len - req_len;
      end
      WR_MERGE_BOTH: begin
        wr_addr       = pos - 1'b1;
        wr_data.start = prev_start;
        wr_data.len   = prev_len + req_len + cur.len;
      end
      WR_MERGE_PREV: begin
        wr_addr       = pos - 1'b1;
        wr_data.start = prev_start;
        wr_data.len   = prev_len + req_len;
      end
      WR_MERGE_NEXT: begin
        wr_data.start = req_first;
        wr_data.len   = cur.len + req_len;
      end
      WR_NEW: begin
        wr_data.start = req_first;
        wr_data.len   = req_len;
      end
      WR_MOVE_DN: wr_addr = cur_idx - 1'b1;
      WR_MOVE_UP: wr_addr = cur_idx + 1'b1;
      default:    wr_addr = pos;
    endcase
  end

  // Working result
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      grant_w  <= '0;
      status_w <= STAT_OK;
    end else begin
      if (cmd.grant_entry) begin
        grant_w <= cur.start;
      end else if (cmd.grant_hw) begin
        grant_w <= high_water[SPACE_BITS-1:0];
      end
      if (cmd.status_set) begin
        status_w <= cmd.status_val;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      granted_first <= grant_w;
      status        <= status_w;
    end
  end

  // High-water check against the limit in force
  assign limit_eff = (space_limit > SPACE_SIZE) ? SPACE_SIZE : space_limit;
  assign hw_sum    = {1'b0, high_water} + {1'b0, req_len};

  // Status to the controller
  always_comb begin
    flags.in_rel_zero = (req_type == REQ_RELEASE) && (range_length == '0);
    flags.req_is_rel  = req_rel == REQ_RELEASE;
    flags.cur_valid   = cur_valid;
    flags.cur_past    = cur_idx >= used;
    flags.fit         = cur.len >= req_len;
    flags.at_or_after = cur.start >= req_first;
    flags.carve_empty = cur.len == req_len;
    flags.hw_ok       = !high_water[SPACE_BITS] && (hw_sum <= {1'b0, limit_eff});
    flags.join_prev   = prev_valid && (prev_end == {1'b0, req_first});
    flags.join_next   = (pos < used) && (req_end == {1'b0, cur.start});
    flags.table_full  = used == SLOTS_CNT;
    flags.pos_at_end  = pos == used;
    flags.cur_at_pos  = cur_idx == pos;
    flags.out_free    = !out_valid || out_ready;
  end

endmodule

### rtl/first_fit_range_allocator.sv
// A zero-length release goes straight to the result. Any other request takes one free-table
// read per entry scanned or moved through the single RAM read port, plus control steps.
// Throughput: one request in flight; the next is taken the cycle after the result is
// registered, and a previous result still waiting on out_ready holds the finish state.
// Reset (sync, rst high): empty free table, high-water zero, space limit 2^SPACE_BITS.
module first_fit_range_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ffra_pkg::LEN_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [ffra_pkg::SPACE_BITS-1:0] range_first,
  input  logic [ffra_pkg::LEN_W-1:0]      range_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ffra_pkg::SPACE_BITS-1:0] granted_first,
  output logic [1:0]                      status
);

  import ffra_pkg::*;

  cmd_t   cmd;
  flags_t flags;

  // Sequencer
  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  // Table, pointers and result registers
  ffra_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req_type      (req_type),
    .range_first   (range_first),
    .range_length  (range_length),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .granted_first (granted_first),
    .status        (status),
    .cmd           (cmd),
    .flags         (flags)
  );

endmodule
